// ===== hdl/i2r_pkg.sv =====
// shared types, symbol codes and digit spelling tables for the roman numeral converter
// no dependencies
package i2r_pkg;

	localparam int unsigned ValueWidth = 12;
	localparam int unsigned SymWidth = 7;
	localparam logic [ValueWidth-1:0] MaxValue = 12'd3999;

	typedef logic [ValueWidth-1:0] value_t;
	typedef logic [SymWidth-1:0] sym_t;
	typedef logic [3:0] nibble_t;
	// index 3 is thousands, index 0 is units
	typedef logic [3:0][3:0] digits_t;

	typedef enum logic [1:0] {
		SLOT_NONE,
		SLOT_ONE,
		SLOT_FIVE,
		SLOT_TEN
	} slot_t;

	typedef struct packed {
		logic start;
		logic err;
		digits_t digits;
	} emit_cmd_t;

	localparam sym_t SymI = 7'h49;
	localparam sym_t SymV = 7'h56;
	localparam sym_t SymX = 7'h58;
	localparam sym_t SymL = 7'h4C;
	localparam sym_t SymC = 7'h43;
	localparam sym_t SymD = 7'h44;
	localparam sym_t SymM = 7'h4D;
	localparam sym_t SymNone = 7'h00;

	function automatic logic [2:0] digit_len(input nibble_t dg);
		logic [2:0] len;
		unique case (dg)
			4'd1, 4'd5: len = 3'd1;
			4'd2, 4'd4, 4'd6, 4'd9: len = 3'd2;
			4'd3, 4'd7: len = 3'd3;
			4'd8: len = 3'd4;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic slot_t digit_slot(input nibble_t dg, input logic [1:0] idx);
		slot_t slot;
		unique case (dg)
			4'd4: slot = (idx == 2'd0) ? SLOT_ONE : SLOT_FIVE;
			4'd9: slot = (idx == 2'd0) ? SLOT_ONE : SLOT_TEN;
			4'd5, 4'd6, 4'd7, 4'd8: slot = (idx == 2'd0) ? SLOT_FIVE : SLOT_ONE;
			4'd1, 4'd2, 4'd3: slot = SLOT_ONE;
			default: slot = SLOT_NONE;
		endcase
		return slot;
	endfunction

	function automatic sym_t decade_sym(input logic [1:0] pos, input slot_t slot);
		sym_t s;
		s = SymNone;
		unique case (pos)
			2'd3: s = (slot == SLOT_ONE) ? SymM : SymNone;
			2'd2: begin
				case (slot)
					SLOT_ONE: s = SymC;
					SLOT_FIVE: s = SymD;
					SLOT_TEN: s = SymM;
					default: s = SymNone;
				endcase
			end
			2'd1: begin
				case (slot)
					SLOT_ONE: s = SymX;
					SLOT_FIVE: s = SymL;
					SLOT_TEN: s = SymC;
					default: s = SymNone;
				endcase
			end
			default: begin
				case (slot)
					SLOT_ONE: s = SymI;
					SLOT_FIVE: s = SymV;
					SLOT_TEN: s = SymX;
					default: s = SymNone;
				endcase
			end
		endcase
		return s;
	endfunction

endpackage

// ===== hdl/i2r_bcd.sv =====
// iterative binary to decimal converter, one shift and add-3 step per cycle
// depends on i2r_pkg
module i2r_bcd
	import i2r_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  value_t  value,
	output logic    done,
	output digits_t digits
);

	localparam int unsigned CntWidth = $clog2(ValueWidth);
	localparam logic [CntWidth-1:0] LastStep = CntWidth'(ValueWidth - 1);

	value_t              bin_q;
	logic [15:0]         bcd_q;
	logic [CntWidth-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [15:0]         adj;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			adj[k*4 +: 4] = (bcd_q[k*4 +: 4] >= 4'd5) ? bcd_q[k*4 +: 4] + 4'd3
				: bcd_q[k*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LastStep) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[14:0], bin_q[ValueWidth-1]};
			bin_q <= {bin_q[ValueWidth-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign digits = bcd_q;

endmodule

// ===== hdl/i2r_emit.sv =====
// character sequencer: spells the decimal digits in turn, one symbol per unstalled cycle
// depends on i2r_pkg
module i2r_emit
	import i2r_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  emit_cmd_t cmd,
	output logic      busy,
	output logic      out_valid,
	input  logic      out_stall,
	output sym_t      symbol,
	output logic      last,
	output logic      out_of_range
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_ERR
	} state_t;

	state_t     state_q;
	digits_t    digits_q;
	logic [1:0] pos_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	sym_t       symbol_q;
	logic       last_q;
	logic       oor_q;

	nibble_t    dg;
	logic [2:0] len;
	logic       end_of_digit;
	logic       rest_zero;
	logic       can_load;
	logic       char_load;

	assign dg = digits_q[pos_q];
	assign len = digit_len(dg);
	assign end_of_digit = ({1'b0, idx_q} == len - 3'd1);
	assign can_load = !out_valid_q || !out_stall;
	assign char_load = can_load && ((state_q == ST_ERR) || (state_q == ST_RUN && len != 3'd0));

	always_comb begin
		rest_zero = 1'b1;
		for (int k = 0; k < 4; k++) begin
			if ((2'(k) < pos_q) && (digits_q[k] != 4'd0)) begin
				rest_zero = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			pos_q <= 2'd3;
			idx_q <= 2'd0;
		end else begin
			out_valid_q <= char_load || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= cmd.err ? ST_ERR : ST_RUN;
						pos_q <= 2'd3;
						idx_q <= 2'd0;
					end
				end
				ST_ERR: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RUN: begin
					if (len == 3'd0) begin
						if (pos_q == 2'd0) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q <= pos_q - 2'd1;
						end
					end else if (can_load) begin
						if (end_of_digit) begin
							idx_q <= 2'd0;
							if (pos_q == 2'd0) begin
								state_q <= ST_IDLE;
							end else begin
								pos_q <= pos_q - 2'd1;
							end
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.start) begin
			digits_q <= cmd.digits;
		end
		if (state_q == ST_ERR && can_load) begin
			symbol_q <= SymNone;
			last_q <= 1'b1;
			oor_q <= 1'b1;
		end else if (state_q == ST_RUN && len != 3'd0 && can_load) begin
			symbol_q <= decade_sym(pos_q, digit_slot(dg, idx_q));
			last_q <= end_of_digit && rest_zero;
			oor_q <= 1'b0;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign symbol = symbol_q;
	assign last = last_q;
	assign out_of_range = oor_q;

endmodule

// ===== hdl/integer_to_roman_numeral.sv =====
// top level of the integer to roman numeral converter
// depends on i2r_pkg, i2r_bcd and i2r_emit
//
// One value is taken at a time; in_stall stays high until the value's last character has
// been placed in the output register. A value from 1 to 3999 first runs through the
// shared shift and add-3 step that splits it into decimal digits, then the sequencer puts
// out one character per cycle while the output is not stalled and steps over each zero
// digit without putting out a character. Zero produces no transfer. A value above 3999
// skips the conversion and gives a single transfer with out_of_range and last set and
// symbol zero. Output stall stretches the character phase.
module integer_to_roman_numeral
	import i2r_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  value_t value,
	output logic   out_valid,
	input  logic   out_stall,
	output sym_t   symbol,
	output logic   last,
	output logic   out_of_range
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t    state_q;
	logic      accept;
	logic      too_big;
	logic      bcd_done;
	digits_t   bcd_digits;
	logic      emit_busy;
	emit_cmd_t cmd;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign too_big = (value > MaxValue);

	always_comb begin
		cmd.start = (accept && too_big) || bcd_done;
		cmd.err = accept && too_big;
		cmd.digits = bcd_digits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= too_big ? ST_EMIT : ST_CONV;
					end
				end
				ST_CONV: begin
					if (bcd_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!emit_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	i2r_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && !too_big),
		.value  (value),
		.done   (bcd_done),
		.digits (bcd_digits)
	);

	i2r_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.busy         (emit_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.symbol       (symbol),
		.last         (last),
		.out_of_range (out_of_range)
	);

endmodule
